[src/satc_pkg.sv]
package satc_pkg;

    localparam int NUM_SETS     = 1024;
    localparam int NUM_WAYS     = 4;
    localparam int PAYLOAD_BITS = 64;
    localparam int SET_BITS     = $clog2(NUM_SETS);
    localparam int WAY_BITS     = $clog2(NUM_WAYS);
    localparam int LINE_BITS    = SET_BITS + WAY_BITS;
    localparam int CTR_BITS     = 2;
    localparam logic [CTR_BITS-1:0] RECENT_TOP = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOOKUP     = 2'd0,
        KIND_INSERT     = 2'd1,
        KIND_INVALIDATE = 2'd2,
        KIND_FLUSH      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef logic [NUM_WAYS-1:0]          valid_t;
    typedef logic [NUM_WAYS*CTR_BITS-1:0] ctr_t;

    // set metadata word: valid bits and recency counters
    typedef struct packed {
        valid_t valid;
        ctr_t   ctr;
    } meta_t;

    // Wang 32-bit integer mixer
    function automatic logic [31:0] mix32(input logic [31:0] k_in);
        logic [31:0] k;
        begin
            k = ~k_in + (k_in << 15);
            k = k ^ (k >> 12);
            k = k + (k << 2);
            k = k ^ (k >> 4);
            k = k + (k << 3) + (k << 11);
            k = k ^ (k >> 16);
            return k;
        end
    endfunction

endpackage

[src/satc_if.sv]
interface satc_req_if;
    import satc_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] subject_key;
    logic [63:0] entry_data_in;
    modport source (output valid, kind, subject_key, entry_data_in, input ready);
    modport sink (input valid, kind, subject_key, entry_data_in, output ready);
endinterface

interface satc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [63:0] entry_data_out;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    modport source (output valid, hit, entry_data_out, hit_total, miss_total, input ready);
    modport sink (input valid, hit, entry_data_out, hit_total, miss_total, output ready);
endinterface

[src/satc_ram.sv]
module satc_ram #(
    parameter int WIDTH = 8,
    parameter int ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/set_assoc_tag_cache_lru.sv]
// Channel | Role   | Payload
// req     | sink   | kind, subject_key, entry_data_in
// rsp     | source | hit, entry_data_out, hit_total, miss_total
// Lookup, insert and invalidate: memory read of the set on acceptance, modify
// and write back in ST_ACCESS; then the result loads and ST_RESULT sets valid.
// The result register holds until taken; the next request is accepted with it.
// Flush and reset each run a clearing pass over all NUM_SETS sets of the set
// metadata memory, one set a cycle; no request is accepted meanwhile.
// Tag and payload stores need no clearing: they are read only behind valid bits.
module set_assoc_tag_cache_lru
    import satc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    satc_req_if.sink   req,
    satc_rsp_if.source rsp
);
    localparam int PB = PAYLOAD_BITS;

    state_t              state_reg, state_next;
    logic [SET_BITS-1:0] set_reg, set_next;
    logic [SET_BITS:0]   clr_reg, clr_next;
    logic [1:0]          kind_reg;
    logic [31:0]         key_reg;
    logic [PB-1:0]       data_reg;
    logic [31:0]         hits_reg, hits_next, miss_reg, miss_next;
    logic                rv_reg, rv_next, rhit_reg, rhit_next;
    logic [63:0]         rdat_reg, rdat_next;

    meta_t               meta_rd, meta_wd;
    logic                meta_we;
    logic [SET_BITS-1:0] meta_wa;
    logic [31:0]         tag_rd   [NUM_WAYS];
    logic [PB-1:0]       pay_rd   [NUM_WAYS];
    logic [NUM_WAYS-1:0] tag_we, pay_we;
    logic [31:0]         tag_wd;
    logic [PB-1:0]       pay_wd;

    logic                take;
    logic [31:0]         req_mix;
    logic [SET_BITS-1:0] req_set;
    logic [NUM_WAYS-1:0] match;
    logic                found, inval_found;
    logic [WAY_BITS-1:0] mway, victim, inval_way;
    logic [CTR_BITS-1:0] best;

    assign req_mix = mix32(req.subject_key);
    assign req_set = req_mix[SET_BITS-1:0];
    assign take    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && (!rv_reg || rsp.ready);

    // set metadata, one word per set
    satc_ram #(.WIDTH($bits(meta_t)), .ADDR_BITS(SET_BITS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
        .raddr(req_set), .rdata(meta_rd)
    );

    // one tag and one payload memory per way
    for (genvar w = 0; w < NUM_WAYS; w++)
    begin : g_way
        satc_ram #(.WIDTH(32), .ADDR_BITS(SET_BITS)) u_tag (
            .clk(clk), .we(tag_we[w]), .waddr(set_reg), .wdata(tag_wd),
            .raddr(req_set), .rdata(tag_rd[w])
        );
        satc_ram #(.WIDTH(PB), .ADDR_BITS(SET_BITS)) u_pay (
            .clk(clk), .we(pay_we[w]), .waddr(set_reg), .wdata(pay_wd),
            .raddr(req_set), .rdata(pay_rd[w])
        );
    end

    // hit detection and victim choice
    always_comb
    begin
        found = 1'b0;
        mway  = '0;
        inval_found = 1'b0;
        inval_way   = '0;
        best   = RECENT_TOP;
        victim = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            match[w] = meta_rd.valid[w] && (tag_rd[w] == key_reg);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                found = 1'b1;
                mway  = WAY_BITS'(w);
            end
            if (!meta_rd.valid[w])
            begin
                inval_found = 1'b1;
                inval_way   = WAY_BITS'(w);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (meta_rd.ctr[w*CTR_BITS +: CTR_BITS] <= best)
            begin
                best   = meta_rd.ctr[w*CTR_BITS +: CTR_BITS];
                victim = WAY_BITS'(w);
            end
        end
        if (inval_found)
        begin
            victim = inval_way;
        end
    end

    // sequencer and read-modify-write of one set
    always_comb
    begin
        state_next = state_reg;
        set_next   = set_reg;
        clr_next   = clr_reg;
        hits_next  = hits_reg;
        miss_next  = miss_reg;
        rv_next    = rv_reg && !rsp.ready;
        rhit_next  = rhit_reg;
        rdat_next  = rdat_reg;
        meta_we    = 1'b0;
        meta_wa    = set_reg;
        meta_wd    = meta_rd;
        tag_we     = '0;
        pay_we     = '0;
        tag_wd     = key_reg;
        pay_wd     = data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    set_next = req_set;
                    if (req.kind == KIND_FLUSH)
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS:
            begin
                rhit_next  = 1'b0;
                rdat_next  = '0;
                state_next = ST_RESULT;
                case (kind_t'(kind_reg))
                    KIND_LOOKUP:
                    begin
                        if (found)
                        begin
                            meta_we = 1'b1;
                            meta_wd.ctr[mway*CTR_BITS +: CTR_BITS] = RECENT_TOP;
                            hits_next = hits_reg + 32'd1;
                            rhit_next = 1'b1;
                            rdat_next = 64'(pay_rd[mway]);
                        end
                        else
                        begin
                            miss_next = miss_reg + 32'd1;
                        end
                    end
                    KIND_INSERT:
                    begin
                        meta_we = 1'b1;
                        if (found)
                        begin
                            pay_we[mway] = 1'b1;
                            meta_wd.ctr[mway*CTR_BITS +: CTR_BITS] = RECENT_TOP;
                        end
                        else
                        begin
                            tag_we[victim] = 1'b1;
                            pay_we[victim] = 1'b1;
                            for (int w = 0; w < NUM_WAYS; w++)
                            begin
                                if (meta_rd.ctr[w*CTR_BITS +: CTR_BITS] != '0)
                                begin
                                    meta_wd.ctr[w*CTR_BITS +: CTR_BITS] =
                                        meta_rd.ctr[w*CTR_BITS +: CTR_BITS] - 2'd1;
                                end
                            end
                            meta_wd.valid[victim] = 1'b1;
                            meta_wd.ctr[victim*CTR_BITS +: CTR_BITS] = RECENT_TOP;
                        end
                    end
                    KIND_INVALIDATE:
                    begin
                        if (found)
                        begin
                            meta_we = 1'b1;
                            meta_wd.valid[mway] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CLEAR:
            begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg[SET_BITS-1:0];
                meta_wd  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SET_BITS+1)'(NUM_SETS - 1))
                begin
                    state_next = (kind_reg == KIND_FLUSH) ? ST_RESULT : ST_IDLE;
                    hits_next  = '0;
                    miss_next  = '0;
                    rhit_next  = 1'b0;
                    rdat_next  = '0;
                end
            end
            ST_RESULT:
            begin
                rv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers; reset starts a clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            set_reg   <= '0;
            kind_reg  <= KIND_LOOKUP;
            hits_reg  <= '0;
            miss_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            set_reg   <= set_next;
            hits_reg  <= hits_next;
            miss_reg  <= miss_next;
            rv_reg    <= rv_next;
            if (take)
            begin
                kind_reg <= req.kind;
            end
        end
    end

    // hold request and result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg  <= req.subject_key;
            data_reg <= req.entry_data_in[PB-1:0];
        end
        rhit_reg <= rhit_next;
        rdat_reg <= rdat_next;
    end

    assign rsp.valid          = rv_reg;
    assign rsp.hit            = rhit_reg;
    assign rsp.entry_data_out = rdat_reg;
    assign rsp.hit_total      = hits_reg;
    assign rsp.miss_total     = miss_reg;

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready) else $error("ready while busy");
    a_access_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS) |=> (state_reg == ST_RESULT))
        else $error("access did not finish");
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT) |=> rsp.valid) else $error("result lost");
    a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.entry_data_out == '0))
        else $error("data on miss");
`endif
endmodule
